### hdl/foc_clarke_park_transform_defines.svh
// ---------------------------------------------------------------------------
// foc_clarke_park_transform_defines
// Assertion macros shared by the transform pipeline.
// ---------------------------------------------------------------------------
`ifndef FOC_CLARKE_PARK_TRANSFORM_DEFINES_SVH
`define FOC_CLARKE_PARK_TRANSFORM_DEFINES_SVH

// same-cycle implication
`define FCPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fcpt_pkg.sv
// ---------------------------------------------------------------------------
// fcpt_pkg
// Types and constants of the Clarke/Park transform pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package fcpt_pkg;

  typedef logic signed [15:0] q16_t;

  localparam int unsigned FRAC       = 14;
  localparam int unsigned NUM_STAGES = 8;

  localparam q16_t K_INV_SQRT3 = 16'sd9459;
  localparam q16_t K_SQRT3     = 16'sd28378;

  localparam q16_t Q16_MAX = 16'sh7FFF;
  localparam q16_t Q16_MIN = 16'sh8000;

  localparam int unsigned CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_COMP_COS = 1'b0;
  localparam cfg_idx_t CFG_COMP_SIN = 1'b1;

  localparam q16_t COMP_COS_RST = 16'sd16384;
  localparam q16_t COMP_SIN_RST = 16'sd0;

endpackage

`default_nettype wire

### hdl/foc_clarke_park_transform.sv
// One word in, one word out, at up to one word per clock while in_stall is
// low. Every word passes through an eight-register pipeline, and its result
// is presented from the last stage and leaves it once out_stall is low. Each
// stage holds either one product layer or one add layer of the Q14 Clarke,
// Park, inverse Park and inverse Clarke math. Stages advance independently:
// a stage loads when it is empty or the stage after it moves, so bubbles
// close up and input is still taken while a finished word waits at the
// output. in_stall rises only when all eight stages hold words and out_stall
// is high. comp_cos and comp_sin are applied at the first stage; the user
// must write them only while the pipeline is empty, as the block itself
// does not enforce it.
// ---------------------------------------------------------------------------
// foc_clarke_park_transform
// Pipelined Q14 Clarke/Park transform with angle compensation and prediction.
// ---------------------------------------------------------------------------
`default_nettype none

`include "foc_clarke_park_transform_defines.svh"

module foc_clarke_park_transform (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire fcpt_pkg::cfg_idx_t       cfg_index,
  input  wire logic [15:0]              cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire fcpt_pkg::q16_t           in_phase_a_current,
  input  wire fcpt_pkg::q16_t           in_phase_b_current,
  input  wire fcpt_pkg::q16_t           in_phase_c_current,
  input  wire fcpt_pkg::q16_t           in_est_sin,
  input  wire fcpt_pkg::q16_t           in_est_cos,
  input  wire fcpt_pkg::q16_t           in_pre_sin,
  input  wire fcpt_pkg::q16_t           in_pre_cos,
  input  wire fcpt_pkg::q16_t           in_volt_d,
  input  wire fcpt_pkg::q16_t           in_volt_q,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output fcpt_pkg::q16_t                out_current_d,
  output fcpt_pkg::q16_t                out_current_q,
  output fcpt_pkg::q16_t                out_volt_alpha,
  output fcpt_pkg::q16_t                out_volt_beta,
  output fcpt_pkg::q16_t                out_pred_current_a,
  output fcpt_pkg::q16_t                out_pred_current_b,
  output fcpt_pkg::q16_t                out_pred_current_c
);

  localparam int NS = int'(fcpt_pkg::NUM_STAGES);

  fcpt_pkg::q16_t comp_cos_r, comp_sin_r;
  logic [NS-1:0]  v_r, v_nxt, en;
  logic           in_fire, out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_cos_r <= fcpt_pkg::COMP_COS_RST;
      comp_sin_r <= fcpt_pkg::COMP_SIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcpt_pkg::CFG_COMP_COS: comp_cos_r <= cfg_data;
        fcpt_pkg::CFG_COMP_SIN: comp_sin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS-1] = ~v_r[NS-1] | ~out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = ~en[0];
  assign out_valid = v_r[NS-1];
  assign in_fire   = in_valid & ~in_stall;
  assign out_fire  = out_valid & ~out_stall;

  fcpt_datapath u_dp (
    .clk             (clk),
    .en              (en),
    .comp_cos        (comp_cos_r),
    .comp_sin        (comp_sin_r),
    .phase_a_current (in_phase_a_current),
    .phase_b_current (in_phase_b_current),
    .phase_c_current (in_phase_c_current),
    .est_sin         (in_est_sin),
    .est_cos         (in_est_cos),
    .pre_sin         (in_pre_sin),
    .pre_cos         (in_pre_cos),
    .volt_d          (in_volt_d),
    .volt_q          (in_volt_q),
    .current_d       (out_current_d),
    .current_q       (out_current_q),
    .volt_alpha      (out_volt_alpha),
    .volt_beta       (out_volt_beta),
    .pred_current_a  (out_pred_current_a),
    .pred_current_b  (out_pred_current_b),
    .pred_current_c  (out_pred_current_c)
  );

  `FCPT_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall, &v_r,
                    "input stalled with a bubble in the pipeline")
  `FCPT_ASSERT_SAME(a_free_output_frees_input, clk, rst_n, !out_stall, !in_stall,
                    "input stalled while output is free")
  `FCPT_ASSERT_NEXT(a_word_count_kept, clk, rst_n, 1'b1,
                    $countones(v_r) == $past($countones(v_r)) + int'($past(in_fire))
                      - int'($past(out_fire)),
                    "word lost or duplicated in pipeline")

endmodule

`default_nettype wire

### hdl/fcpt_datapath.sv
// ---------------------------------------------------------------------------
// fcpt_datapath
// Eight-stage Clarke, Park, inverse Park and inverse Clarke arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

module fcpt_datapath (
  input  wire logic                               clk,
  input  wire logic [fcpt_pkg::NUM_STAGES-1:0]    en,
  input  wire fcpt_pkg::q16_t                     comp_cos,
  input  wire fcpt_pkg::q16_t                     comp_sin,
  input  wire fcpt_pkg::q16_t                     phase_a_current,
  input  wire fcpt_pkg::q16_t                     phase_b_current,
  input  wire fcpt_pkg::q16_t                     phase_c_current,
  input  wire fcpt_pkg::q16_t                     est_sin,
  input  wire fcpt_pkg::q16_t                     est_cos,
  input  wire fcpt_pkg::q16_t                     pre_sin,
  input  wire fcpt_pkg::q16_t                     pre_cos,
  input  wire fcpt_pkg::q16_t                     volt_d,
  input  wire fcpt_pkg::q16_t                     volt_q,
  output fcpt_pkg::q16_t                          current_d,
  output fcpt_pkg::q16_t                          current_q,
  output fcpt_pkg::q16_t                          volt_alpha,
  output fcpt_pkg::q16_t                          volt_beta,
  output fcpt_pkg::q16_t                          pred_current_a,
  output fcpt_pkg::q16_t                          pred_current_b,
  output fcpt_pkg::q16_t                          pred_current_c
);

  localparam int FR      = int'(fcpt_pkg::FRAC);
  localparam int DIF_W   = 17;
  localparam int PBETA_W = 32;
  localparam int BETA_W  = PBETA_W - FR;
  localparam int P16_W   = 32;
  localparam int ROT_W   = P16_W + 1;
  localparam int ANG_W   = ROT_W - FR;
  localparam int MIX_W   = BETA_W + ANG_W;
  localparam int MIXS_W  = MIX_W + 1;
  localparam int DQ_W    = MIXS_W - FR;
  localparam int PRE_W   = 16 + ANG_W;
  localparam int PRES_W  = PRE_W + 1;
  localparam int PANG_W  = PRES_W - FR;
  localparam int VP_W    = 16 + PANG_W;
  localparam int VS_W    = VP_W + 1;
  localparam int V_W     = VS_W - FR;
  localparam int IP_W    = DQ_W + PANG_W;
  localparam int IS_W    = IP_W + 1;
  localparam int PI_W    = IS_W - FR;
  localparam int S3P_W   = PI_W + 16;
  localparam int S3_W    = S3P_W - FR;
  localparam int PHS_W   = S3_W + 1;
  localparam int SAT_W   = 40;

  function automatic fcpt_pkg::q16_t sat16(input logic signed [SAT_W-1:0] x);
    fcpt_pkg::q16_t r;
    if (x > SAT_W'(fcpt_pkg::Q16_MAX)) begin
      r = fcpt_pkg::Q16_MAX;
    end else if (x < SAT_W'(fcpt_pkg::Q16_MIN)) begin
      r = fcpt_pkg::Q16_MIN;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // stage 0: Clarke difference product, angle compensation products
  logic signed [DIF_W-1:0]   dif;
  logic signed [PBETA_W-1:0] s0_pbeta_r;
  logic signed [P16_W-1:0]   s0_es_cc_r, s0_ec_cs_r, s0_ec_cc_r, s0_es_cs_r;
  fcpt_pkg::q16_t            s0_alpha_r, s0_ps_r, s0_pc_r, s0_vd_r, s0_vq_r;

  assign dif = DIF_W'(phase_b_current) - DIF_W'(phase_c_current);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_pbeta_r <= PBETA_W'(dif) * PBETA_W'(fcpt_pkg::K_INV_SQRT3);
      s0_es_cc_r <= P16_W'(est_sin) * P16_W'(comp_cos);
      s0_ec_cs_r <= P16_W'(est_cos) * P16_W'(comp_sin);
      s0_ec_cc_r <= P16_W'(est_cos) * P16_W'(comp_cos);
      s0_es_cs_r <= P16_W'(est_sin) * P16_W'(comp_sin);
      s0_alpha_r <= phase_a_current;
      s0_ps_r    <= pre_sin;
      s0_pc_r    <= pre_cos;
      s0_vd_r    <= volt_d;
      s0_vq_r    <= volt_q;
    end
  end

  // stage 1: beta and compensated angle
  logic signed [ROT_W-1:0]  sin_sum, cos_sum;
  logic signed [BETA_W-1:0] s1_beta_r;
  logic signed [ANG_W-1:0]  s1_sr_r, s1_cr_r;
  fcpt_pkg::q16_t           s1_alpha_r, s1_ps_r, s1_pc_r, s1_vd_r, s1_vq_r;

  assign sin_sum = ROT_W'(s0_es_cc_r) + ROT_W'(s0_ec_cs_r);
  assign cos_sum = ROT_W'(s0_ec_cc_r) - ROT_W'(s0_es_cs_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_beta_r  <= s0_pbeta_r[PBETA_W-1:FR];
      s1_sr_r    <= sin_sum[ROT_W-1:FR];
      s1_cr_r    <= cos_sum[ROT_W-1:FR];
      s1_alpha_r <= s0_alpha_r;
      s1_ps_r    <= s0_ps_r;
      s1_pc_r    <= s0_pc_r;
      s1_vd_r    <= s0_vd_r;
      s1_vq_r    <= s0_vq_r;
    end
  end

  // stage 2: Park and predictive rotation products
  logic signed [MIX_W-1:0] s2_acr_r, s2_bsr_r, s2_bcr_r, s2_asr_r;
  logic signed [PRE_W-1:0] s2_srpc_r, s2_crps_r, s2_crpc_r, s2_srps_r;
  fcpt_pkg::q16_t          s2_vd_r, s2_vq_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_acr_r  <= MIX_W'(s1_alpha_r) * MIX_W'(s1_cr_r);
      s2_bsr_r  <= MIX_W'(s1_beta_r) * MIX_W'(s1_sr_r);
      s2_bcr_r  <= MIX_W'(s1_beta_r) * MIX_W'(s1_cr_r);
      s2_asr_r  <= MIX_W'(s1_alpha_r) * MIX_W'(s1_sr_r);
      s2_srpc_r <= PRE_W'(s1_sr_r) * PRE_W'(s1_pc_r);
      s2_crps_r <= PRE_W'(s1_cr_r) * PRE_W'(s1_ps_r);
      s2_crpc_r <= PRE_W'(s1_cr_r) * PRE_W'(s1_pc_r);
      s2_srps_r <= PRE_W'(s1_sr_r) * PRE_W'(s1_ps_r);
      s2_vd_r   <= s1_vd_r;
      s2_vq_r   <= s1_vq_r;
    end
  end

  // stage 3: d/q currents and predicted angle
  logic signed [MIXS_W-1:0] id_sum, iq_sum;
  logic signed [PRES_W-1:0] sp_sum, cp_sum;
  logic signed [DQ_W-1:0]   s3_id_r, s3_iq_r;
  logic signed [PANG_W-1:0] s3_sp_r, s3_cp_r;
  fcpt_pkg::q16_t           s3_vd_r, s3_vq_r;

  assign id_sum = MIXS_W'(s2_acr_r) + MIXS_W'(s2_bsr_r);
  assign iq_sum = MIXS_W'(s2_bcr_r) - MIXS_W'(s2_asr_r);
  assign sp_sum = PRES_W'(s2_srpc_r) + PRES_W'(s2_crps_r);
  assign cp_sum = PRES_W'(s2_crpc_r) - PRES_W'(s2_srps_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_id_r <= id_sum[MIXS_W-1:FR];
      s3_iq_r <= iq_sum[MIXS_W-1:FR];
      s3_sp_r <= sp_sum[PRES_W-1:FR];
      s3_cp_r <= cp_sum[PRES_W-1:FR];
      s3_vd_r <= s2_vd_r;
      s3_vq_r <= s2_vq_r;
    end
  end

  // stage 4: inverse Park products, saturate d/q currents
  logic signed [VP_W-1:0] s4_vdcp_r, s4_vqsp_r, s4_vdsp_r, s4_vqcp_r;
  logic signed [IP_W-1:0] s4_idcp_r, s4_iqsp_r, s4_idsp_r, s4_iqcp_r;
  fcpt_pkg::q16_t         s4_cur_d_r, s4_cur_q_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_vdcp_r  <= VP_W'(s3_vd_r) * VP_W'(s3_cp_r);
      s4_vqsp_r  <= VP_W'(s3_vq_r) * VP_W'(s3_sp_r);
      s4_vdsp_r  <= VP_W'(s3_vd_r) * VP_W'(s3_sp_r);
      s4_vqcp_r  <= VP_W'(s3_vq_r) * VP_W'(s3_cp_r);
      s4_idcp_r  <= IP_W'(s3_id_r) * IP_W'(s3_cp_r);
      s4_iqsp_r  <= IP_W'(s3_iq_r) * IP_W'(s3_sp_r);
      s4_idsp_r  <= IP_W'(s3_id_r) * IP_W'(s3_sp_r);
      s4_iqcp_r  <= IP_W'(s3_iq_r) * IP_W'(s3_cp_r);
      s4_cur_d_r <= sat16(SAT_W'(s3_id_r));
      s4_cur_q_r <= sat16(SAT_W'(s3_iq_r));
    end
  end

  // stage 5: alpha/beta voltages and predicted alpha/beta currents
  logic signed [VS_W-1:0] va_sum, vb_sum;
  logic signed [IS_W-1:0] pa_sum, pb_sum;
  logic signed [V_W-1:0]  s5_va_r, s5_vb_r;
  logic signed [PI_W-1:0] s5_pa_r, s5_pb_r;
  fcpt_pkg::q16_t         s5_cur_d_r, s5_cur_q_r;

  assign va_sum = VS_W'(s4_vdcp_r) - VS_W'(s4_vqsp_r);
  assign vb_sum = VS_W'(s4_vdsp_r) + VS_W'(s4_vqcp_r);
  assign pa_sum = IS_W'(s4_idcp_r) - IS_W'(s4_iqsp_r);
  assign pb_sum = IS_W'(s4_idsp_r) + IS_W'(s4_iqcp_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_va_r    <= va_sum[VS_W-1:FR];
      s5_vb_r    <= vb_sum[VS_W-1:FR];
      s5_pa_r    <= pa_sum[IS_W-1:FR];
      s5_pb_r    <= pb_sum[IS_W-1:FR];
      s5_cur_d_r <= s4_cur_d_r;
      s5_cur_q_r <= s4_cur_q_r;
    end
  end

  // stage 6: sqrt3 * beta product, saturate voltages and phase A
  logic signed [S3P_W-1:0] s6_s3p_r;
  logic signed [PI_W-1:0]  s6_pa_r;
  fcpt_pkg::q16_t          s6_cur_d_r, s6_cur_q_r, s6_va_r, s6_vb_r, s6_pa_sat_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_s3p_r    <= S3P_W'(s5_pb_r) * S3P_W'(fcpt_pkg::K_SQRT3);
      s6_pa_r     <= s5_pa_r;
      s6_pa_sat_r <= sat16(SAT_W'(s5_pa_r));
      s6_va_r     <= sat16(SAT_W'(s5_va_r));
      s6_vb_r     <= sat16(SAT_W'(s5_vb_r));
      s6_cur_d_r  <= s5_cur_d_r;
      s6_cur_q_r  <= s5_cur_q_r;
    end
  end

  // stage 7: inverse Clarke for phases B and C, output word
  logic signed [S3_W-1:0]  s3b;
  logic signed [PHS_W-1:0] ph_b, ph_c;
  fcpt_pkg::q16_t          s7_cur_d_r, s7_cur_q_r, s7_va_r, s7_vb_r;
  fcpt_pkg::q16_t          s7_pa_r, s7_pb_r, s7_pc_r;

  assign s3b  = s6_s3p_r[S3P_W-1:FR];
  assign ph_b = PHS_W'(s3b) - PHS_W'(s6_pa_r);
  assign ph_c = -PHS_W'(s6_pa_r) - PHS_W'(s3b);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_cur_d_r <= s6_cur_d_r;
      s7_cur_q_r <= s6_cur_q_r;
      s7_va_r    <= s6_va_r;
      s7_vb_r    <= s6_vb_r;
      s7_pa_r    <= s6_pa_sat_r;
      s7_pb_r    <= sat16(SAT_W'($signed(ph_b[PHS_W-1:15])));
      s7_pc_r    <= sat16(SAT_W'($signed(ph_c[PHS_W-1:15])));
    end
  end

  assign current_d      = s7_cur_d_r;
  assign current_q      = s7_cur_q_r;
  assign volt_alpha     = s7_va_r;
  assign volt_beta      = s7_vb_r;
  assign pred_current_a = s7_pa_r;
  assign pred_current_b = s7_pb_r;
  assign pred_current_c = s7_pc_r;

endmodule

`default_nettype wire
